// ===== hw/rtl/csns_pkg.sv =====
package csns_pkg;

    // Scanner modes.
    typedef enum logic [3:0] {
        MODE_NORMAL     = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_BLOCK      = 4'd2,
        MODE_BLOCK_STAR = 4'd3,
        MODE_LINE       = 4'd4,
        MODE_DIR        = 4'd5,
        MODE_DIR_BS     = 4'd6,
        MODE_QUOTE      = 4'd7,
        MODE_QUOTE_ESC  = 4'd8
    } mode_t;

    // Character codes that the scanner recognises or produces.
    localparam logic [7:0] CHR_SLASH     = 8'h2F;
    localparam logic [7:0] CHR_STAR      = 8'h2A;
    localparam logic [7:0] CHR_HASH      = 8'h23;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_NUL       = 8'h00;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       valid_byte;
        logic       last;
    } res_t;

    // Everything one input item produces: up to two results.
    typedef struct packed {
        res_t       r0;
        res_t       r1;
        logic [1:0] count;
    } step_t;

endpackage

// ===== hw/rtl/csns_scanner.sv =====
module csns_scanner import csns_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_data,
    input  logic       in_last,
    output step_t      step
);

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        mode_t      mode;
        logic       qk;
        logic       ls;
    } plain_t;

    mode_t mode_reg, mode_next;
    logic  qk_reg, qk_next;
    logic  ls_reg, ls_next;

    // Handling of a byte as plain text.
    function automatic plain_t plain_fn(input logic [7:0] c, input logic last_i,
                                        input logic ls, input logic qk);
        plain_t p;
        p.emit = 1'b0;
        p.data = c;
        p.mode = MODE_NORMAL;
        p.qk   = qk;
        p.ls   = ls;
        if (c == CHR_SLASH) begin
            if (last_i) begin
                p.emit = 1'b1;
                p.ls   = 1'b0;
            end else begin
                p.mode = MODE_SLASH;
            end
        end else if (ls && c == CHR_HASH) begin
            p.mode = MODE_DIR;
        end else if (c == CHR_DQUOTE || c == CHR_SQUOTE) begin
            p.emit = 1'b1;
            p.data = CHR_SPACE;
            p.qk   = (c == CHR_SQUOTE);
            p.mode = MODE_QUOTE;
        end else begin
            p.emit = 1'b1;
            p.ls   = (c == CHR_NEWLINE);
        end
        return p;
    endfunction

    // Next state and the results of the current item.
    always_comb begin
        plain_t     p;
        logic       e0v, e1v;
        logic [7:0] e0, e1;
        p         = plain_fn(in_data, in_last, ls_reg, qk_reg);
        mode_next = mode_reg;
        qk_next   = qk_reg;
        ls_next   = ls_reg;
        e0v       = 1'b0;
        e1v       = 1'b0;
        e0        = CHR_NUL;
        e1        = CHR_NUL;
        case (mode_reg)
            MODE_NORMAL: begin
                e0v = p.emit; e0 = p.data;
                mode_next = p.mode; qk_next = p.qk; ls_next = p.ls;
            end
            MODE_SLASH: begin
                if (in_data == CHR_STAR) begin
                    e0v = 1'b1; e0 = CHR_SPACE;
                    mode_next = MODE_BLOCK;
                end else if (in_data == CHR_SLASH) begin
                    mode_next = MODE_LINE;
                end else begin
                    // The held slash goes out first; the byte is then plain text.
                    p   = plain_fn(in_data, in_last, 1'b0, qk_reg);
                    e0v = 1'b1; e0 = CHR_SLASH;
                    e1v = p.emit; e1 = p.data;
                    mode_next = p.mode; qk_next = p.qk; ls_next = p.ls;
                end
            end
            MODE_BLOCK: begin
                if (in_data == CHR_STAR) mode_next = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (in_data == CHR_SLASH) begin
                    mode_next = MODE_NORMAL;
                end else if (in_data != CHR_STAR) begin
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_LINE: begin
                if (in_data == CHR_NEWLINE) begin
                    e0v = p.emit; e0 = p.data;
                    mode_next = p.mode; qk_next = p.qk; ls_next = p.ls;
                end
            end
            MODE_DIR, MODE_DIR_BS: begin
                if (in_data == CHR_NEWLINE) begin
                    if (mode_reg == MODE_DIR_BS) begin
                        mode_next = MODE_DIR;
                    end else begin
                        e0v = p.emit; e0 = p.data;
                        mode_next = p.mode; qk_next = p.qk; ls_next = p.ls;
                    end
                end else begin
                    mode_next = (in_data == CHR_BACKSLASH) ? MODE_DIR_BS : MODE_DIR;
                end
            end
            MODE_QUOTE: begin
                if (in_data == (qk_reg ? CHR_SQUOTE : CHR_DQUOTE)) begin
                    mode_next = MODE_NORMAL;
                end else if (in_data == CHR_BACKSLASH) begin
                    mode_next = MODE_QUOTE_ESC;
                end
            end
            MODE_QUOTE_ESC: begin
                mode_next = MODE_QUOTE;
            end
            default: begin
                e0v = p.emit; e0 = p.data;
                mode_next = p.mode; qk_next = p.qk; ls_next = p.ls;
            end
        endcase

        step.r0    = '{data: e0, valid_byte: 1'b1, last: 1'b0};
        step.r1    = '{data: e1, valid_byte: 1'b1, last: 1'b0};
        step.count = {1'b0, e0v} + {1'b0, e1v};

        // The final byte marks its last result, or a bare end marker, and resets.
        if (in_last) begin
            if (step.count == 2'd0) begin
                step.r0    = '{data: CHR_NUL, valid_byte: 1'b0, last: 1'b1};
                step.count = 2'd1;
            end else if (step.count == 2'd2) begin
                step.r1.last = 1'b1;
            end else begin
                step.r0.last = 1'b1;
            end
            mode_next = MODE_NORMAL;
            qk_next   = 1'b0;
            ls_next   = 1'b1;
        end
    end

    // State registers advance on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            qk_reg   <= 1'b0;
            ls_reg   <= 1'b1;
        end else if (accept) begin
            mode_reg <= mode_next;
            qk_reg   <= qk_next;
            ls_reg   <= ls_next;
        end
    end

    // The final byte always leaves the scanner as after reset.
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_last |=> mode_reg == MODE_NORMAL && ls_reg && !qk_reg)
        else $error("scanner state not restored after final byte");

    // A bare end marker only appears as the final result.
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !step.r0.valid_byte |-> step.r0.last && step.count == 2'd1)
        else $error("end marker without last flag");

endmodule

// ===== hw/rtl/csns_out_queue.sv =====
module csns_out_queue import csns_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  step_t step,
    output logic  can_push,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    localparam int Depth = 3;

    res_t       q_reg  [Depth];
    res_t       q_next [Depth];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;
    logic [1:0] add;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - {1'b0, pop};
    // Room for two results after this cycle's pop.
    assign can_push  = (base <= 2'd1);
    assign add       = push ? step.count : 2'd0;

    // Shift out on pop and append the new results behind what remains.
    always_comb begin
        for (int i = 0; i < Depth; i++) begin
            if (pop && i < Depth - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push && step.count != 2'd0 && base == 2'(i)) begin
                q_next[i] = step.r0;
            end
            if (push && step.count == 2'd2 && base + 2'd1 == 2'(i)) begin
                q_next[i] = step.r1;
            end
        end
        count_next = base + add;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Depth; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // An item is only taken while two free entries are guaranteed.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> base <= 2'd1)
        else $error("item taken without room for its results");

    // A pop with no new results shrinks the queue by one.
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count wrong after pop");

    // Pushing two results while nothing leaves grows the queue by two.
    a_push_two: assert property (@(posedge aclk) disable iff (!aresetn)
        push && step.count == 2'd2 && !pop |=> count_reg == $past(count_reg) + 2'd2)
        else $error("queue count wrong after double push");

endmodule

// ===== hw/rtl/c_source_noise_stripper.sv =====
// Channel | Direction | tdata        | tuser              | tlast
// s_      | in        | [7:0] in_byte | -                  | in_last
// m_      | out       | [7:0] out_byte| [0] out_valid_byte | out_last
//
// One input item per cycle while s_tready is high, with results leaving from a registered three-entry queue.
// An item that releases a held slash yields two results; the single output port
// drains them at one per cycle while m_tready is high, so the input pauses after such an item
// while fewer than two queue entries will be free.
// Reset is synchronous, active low, and empties the queue and restarts the scanner.
// s_tready stays high while at least two queue entries will be free after this cycle.
module c_source_noise_stripper import csns_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] out_valid_byte
    output logic       m_tlast
);

    logic  accept;
    step_t step;
    res_t  head;

    assign accept = s_tvalid && s_tready;

    // Mode tracking and result generation.
    csns_scanner u_scanner (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_data (s_tdata),
        .in_last (s_tlast),
        .step    (step)
    );

    // Result register and queue.
    csns_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .step      (step),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    assign m_tdata    = head.data;
    assign m_tuser[0] = head.valid_byte;
    assign m_tlast    = head.last;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csns_pkg::*;

    localparam int ITEM_TARGET = 1400;
    localparam int DRILL_ROWS  = 25;
    localparam int HOLD_CYCLES = 80;

    // One row of the directed stimulus: the item, and its results where typed in.
    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       typed;
        step_t      want;
    } drill_row_t;

    // Fragments from which random sources are assembled.
    typedef enum int {
        FRAG_TEXT, FRAG_NEWLINE, FRAG_BLOCK, FRAG_LINE,
        FRAG_DIRECTIVE, FRAG_QUOTED, FRAG_LONE_SLASH, FRAG_NOISE
    } frag_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [0:0] m_tuser;    // [0] out_valid_byte
    logic       m_tlast;

    // Side information travelling with the item on offer.
    logic       row_typed;
    step_t      row_want;

    // Scanner state of the predictor.
    mode_t      scan_st;
    logic       quote_single;
    logic       pred_line_start;
    step_t      cur_step;

    res_t       pending_q[$];
    logic [7:0] src_bytes[$];
    int         fail_count;
    int         items_sent;
    bit         rx_hold_req;

    drill_row_t drill_rows [DRILL_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, '{'{8'h00, 1'b1, 1'b0}, '0, 2'd1}},
        '{8'hFF, 1'b0, 1'b1, '{'{8'hFF, 1'b1, 1'b0}, '0, 2'd1}},
        '{CHR_NEWLINE, 1'b0, 1'b1, '{'{CHR_NEWLINE, 1'b1, 1'b0}, '0, 2'd1}},
        '{CHR_HASH, 1'b0, 1'b1, '0},
        '{CHR_BACKSLASH, 1'b0, 1'b0, '0},
        '{CHR_NEWLINE, 1'b0, 1'b0, '0},
        '{8'h78, 1'b0, 1'b0, '0},
        '{CHR_NEWLINE, 1'b0, 1'b1, '{'{CHR_NEWLINE, 1'b1, 1'b0}, '0, 2'd1}},
        '{CHR_SLASH, 1'b0, 1'b1, '0},
        '{8'h61, 1'b0, 1'b1,
          '{'{CHR_SLASH, 1'b1, 1'b0}, '{8'h61, 1'b1, 1'b0}, 2'd2}},
        '{CHR_HASH, 1'b0, 1'b0, '0},
        '{CHR_SLASH, 1'b0, 1'b0, '0},
        '{CHR_STAR, 1'b0, 1'b1, '{'{CHR_SPACE, 1'b1, 1'b0}, '0, 2'd1}},
        '{CHR_STAR, 1'b0, 1'b0, '0},
        '{CHR_STAR, 1'b0, 1'b0, '0},
        '{CHR_SLASH, 1'b0, 1'b0, '0},
        '{CHR_DQUOTE, 1'b0, 1'b1, '{'{CHR_SPACE, 1'b1, 1'b0}, '0, 2'd1}},
        '{CHR_BACKSLASH, 1'b0, 1'b0, '0},
        '{CHR_DQUOTE, 1'b0, 1'b0, '0},
        '{CHR_DQUOTE, 1'b0, 1'b0, '0},
        '{CHR_SLASH, 1'b0, 1'b0, '0},
        '{CHR_SLASH, 1'b0, 1'b0, '0},
        '{8'h71, 1'b1, 1'b1, '{'{CHR_NUL, 1'b0, 1'b1}, '0, 2'd1}},
        '{CHR_SLASH, 1'b1, 1'b1, '{'{CHR_SLASH, 1'b1, 1'b1}, '0, 2'd1}},
        '{CHR_SQUOTE, 1'b1, 1'b1, '{'{CHR_SPACE, 1'b1, 1'b1}, '0, 2'd1}}
    };

    c_source_noise_stripper dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 10 ns period.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor: appends one passed byte to the results of the current item.
    function automatic void emit_byte(logic [7:0] b);
        if (cur_step.count == 2'd0) begin
            cur_step.r0 = '{b, 1'b1, 1'b0};
            cur_step.count = 2'd1;
        end else if (cur_step.count == 2'd1) begin
            cur_step.r1 = '{b, 1'b1, 1'b0};
            cur_step.count = 2'd2;
        end
    endfunction

    // Predictor: a byte met in plain text.
    function automatic void take_plain(logic [7:0] c, logic l);
        if (c == CHR_SLASH) begin
            if (l) begin
                emit_byte(CHR_SLASH);
                pred_line_start = 1'b0;
            end else begin
                scan_st = MODE_SLASH;
            end
        end else if (pred_line_start && c == CHR_HASH) begin
            scan_st = MODE_DIR;
        end else if (c == CHR_DQUOTE || c == CHR_SQUOTE) begin
            emit_byte(CHR_SPACE);
            quote_single = (c == CHR_SQUOTE);
            scan_st = MODE_QUOTE;
        end else begin
            emit_byte(c);
            pred_line_start = (c == CHR_NEWLINE);
            scan_st = MODE_NORMAL;
        end
    endfunction

    function automatic void restart_scan();
        scan_st = MODE_NORMAL;
        quote_single = 1'b0;
        pred_line_start = 1'b1;
    endfunction

    // Predictor: works out every result caused by one accepted item.
    function automatic step_t strip_byte(logic [7:0] c, logic l);
        logic [7:0] closing;
        cur_step = '0;
        case (scan_st)
            MODE_NORMAL: begin
                take_plain(c, l);
            end
            MODE_SLASH: begin
                if (c == CHR_STAR) begin
                    emit_byte(CHR_SPACE);
                    scan_st = MODE_BLOCK;
                end else if (c == CHR_SLASH) begin
                    scan_st = MODE_LINE;
                end else begin
                    emit_byte(CHR_SLASH);
                    pred_line_start = 1'b0;
                    scan_st = MODE_NORMAL;
                    take_plain(c, l);
                end
            end
            MODE_BLOCK: begin
                if (c == CHR_STAR) scan_st = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                if (c == CHR_SLASH) scan_st = MODE_NORMAL;
                else if (c != CHR_STAR) scan_st = MODE_BLOCK;
            end
            MODE_LINE: begin
                if (c == CHR_NEWLINE) take_plain(c, l);
            end
            MODE_DIR, MODE_DIR_BS: begin
                if (c == CHR_NEWLINE) begin
                    if (scan_st == MODE_DIR_BS) scan_st = MODE_DIR;
                    else take_plain(c, l);
                end else begin
                    scan_st = (c == CHR_BACKSLASH) ? MODE_DIR_BS : MODE_DIR;
                end
            end
            MODE_QUOTE: begin
                closing = quote_single ? CHR_SQUOTE : CHR_DQUOTE;
                if (c == closing) scan_st = MODE_NORMAL;
                else if (c == CHR_BACKSLASH) scan_st = MODE_QUOTE_ESC;
            end
            MODE_QUOTE_ESC: begin
                scan_st = MODE_QUOTE;
            end
            default: begin
                scan_st = MODE_NORMAL;
                take_plain(c, l);
            end
        endcase
        // The final byte closes the source, with a bare end marker if nothing was passed.
        if (l) begin
            if (cur_step.count == 2'd0) begin
                cur_step.r0 = '{CHR_NUL, 1'b0, 1'b1};
                cur_step.count = 2'd1;
            end else if (cur_step.count == 2'd1) begin
                cur_step.r0.last = 1'b1;
            end else begin
                cur_step.r1.last = 1'b1;
            end
            restart_scan();
        end
        return cur_step;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A byte for the inside of a comment, directive or literal, biased to the marks.
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 11))
            0:       return CHR_STAR;
            1:       return CHR_SLASH;
            2:       return CHR_BACKSLASH;
            3:       return CHR_NEWLINE;
            4:       return CHR_DQUOTE;
            5:       return CHR_SQUOTE;
            6:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h20, 8'h7E));
        endcase
    endfunction

    // Appends one byte to the source under construction.
    function automatic void add_src(logic [7:0] b);
        src_bytes = {src_bytes, b};
    endfunction

    // Assembles one random source in src_bytes, mostly well formed.
    function automatic void build_source();
        frag_t kind;
        int    n_frags;
        int    n;
        src_bytes.delete();
        n_frags = $urandom_range(1, 10);
        for (int f = 0; f < n_frags; f++) begin
            kind = frag_t'($urandom_range(0, 7));
            n = $urandom_range(0, 5);
            case (kind)
                FRAG_TEXT: begin
                    for (int i = 0; i <= n; i++)
                        add_src(8'($urandom_range(8'h20, 8'h7E)));
                end
                FRAG_NEWLINE: begin
                    add_src(CHR_NEWLINE);
                end
                FRAG_BLOCK: begin
                    add_src(CHR_SLASH);
                    add_src(CHR_STAR);
                    for (int i = 0; i < n; i++) add_src(body_byte());
                    if ($urandom_range(0, 1)) add_src(CHR_STAR);
                    add_src(CHR_STAR);
                    add_src(CHR_SLASH);
                end
                FRAG_LINE: begin
                    add_src(CHR_SLASH);
                    add_src(CHR_SLASH);
                    for (int i = 0; i < n; i++) add_src(body_byte());
                    add_src(CHR_NEWLINE);
                end
                FRAG_DIRECTIVE: begin
                    // A newline first, so that the hash stands at the start of a line.
                    add_src(CHR_NEWLINE);
                    add_src(CHR_HASH);
                    for (int i = 0; i < n; i++) begin
                        add_src(body_byte());
                        if ($urandom_range(0, 3) == 0) begin
                            add_src(CHR_BACKSLASH);
                            add_src(CHR_NEWLINE);
                        end
                    end
                    add_src(CHR_NEWLINE);
                end
                FRAG_QUOTED: begin
                    add_src($urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE);
                    for (int i = 0; i < n; i++) begin
                        if ($urandom_range(0, 3) == 0) add_src(CHR_BACKSLASH);
                        add_src(body_byte());
                    end
                    add_src($urandom_range(0, 1) ? CHR_SQUOTE : CHR_DQUOTE);
                end
                FRAG_LONE_SLASH: begin
                    add_src(CHR_SLASH);
                    add_src(body_byte());
                end
                default: begin
                    add_src(8'($urandom_range(0, 255)));
                end
            endcase
        end
        // Now and then the source is cut short, leaving a construct open.
        if ($urandom_range(0, 7) == 0 && src_bytes.size() > 1)
            src_bytes = src_bytes[0:$urandom_range(0, src_bytes.size() - 2)];
    endfunction

    // Offers one item and returns at the falling edge after its acceptance.
    task automatic send_item(logic [7:0] b, logic l, logic typed, step_t want);
        s_tdata   <= b;
        s_tlast   <= l;
        row_typed <= typed;
        row_want  <= want;
        s_tvalid  <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic sender_idle(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge aclk);
    endtask

    // Input side: reset, directed table, then random sources.
    initial begin
        int  src_idx;
        int  calm_sources;
        bit  calm;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        row_typed  = 1'b0;
        row_want   = '0;
        fail_count = 0;
        items_sent = 0;
        rx_hold_req = 1'b0;
        restart_scan();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DRILL_ROWS; i++) begin
            send_item(drill_rows[i].b, drill_rows[i].l, drill_rows[i].typed,
                      drill_rows[i].want);
            sender_idle(pick_gap());
        end
        drain_results();

        src_idx = 0;
        calm_sources = 0;
        while (items_sent < ITEM_TARGET) begin
            build_source();
            // Long receiver hold-off while the sender keeps offering items.
            if (src_idx == 5) begin
                rx_hold_req = 1'b1;
                calm_sources = 4;
            end
            // Sender pause until every expected result has come.
            if (src_idx == 30) drain_results();
            calm = (calm_sources > 0) || ($urandom_range(0, 4) == 0);
            if (calm_sources > 0) calm_sources--;
            for (int i = 0; i < src_bytes.size(); i++) begin
                send_item(src_bytes[i], i == src_bytes.size() - 1, 1'b0, '0);
                if (!calm) sender_idle(pick_gap());
            end
            src_idx++;
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Output side: random back-pressure, with one long hold-off on request.
    initial begin
        int rx_gap;
        int calm_left;
        m_tready = 1'b0;
        rx_gap = 0;
        calm_left = 0;
        forever begin
            @(negedge aclk);
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(50, 200);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (rx_gap > 0) begin
                m_tready <= 1'b0;
                rx_gap--;
            end else begin
                m_tready <= 1'b1;
                rx_gap = (calm_left > 0) ? 0 : pick_gap();
            end
        end
    end

    // Each accepted item adds its expected results; each accepted result is checked.
    always @(posedge aclk) begin
        step_t got_step;
        res_t  want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                got_step = strip_byte(s_tdata, s_tlast);
                if (row_typed) got_step = row_want;
                if (got_step.count >= 2'd1) pending_q = {pending_q, got_step.r0};
                if (got_step.count == 2'd2) pending_q = {pending_q, got_step.r1};
            end
            if (m_tvalid && m_tready) begin
                if (pending_q.size() == 0) begin
                    $error("unexpected result item: out_byte %h", m_tdata);
                    fail_count++;
                end else begin
                    want = pending_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte mismatch: expected %h, got %h", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.valid_byte) begin
                        $error("out_valid_byte mismatch: expected %b, got %b",
                               want.valid_byte, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("out_last mismatch: expected %b, got %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog for a hung run.
    initial begin
        #8_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
